>>> design/mpq_pkg.sv
// mpq_pkg: shared sizes, codes, entry and cell control types for the priority queue
// no dependencies
package mpq_pkg;

    localparam int DEPTH      = 16;
    localparam int PRIO_WIDTH = 16;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_REMOVED = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [31:0]                  value;
        logic signed [PRIO_WIDTH-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic take_next;
        logic take_new;
    } cell_ctrl_t;

endpackage

>>> design/mpq_cell.sv
// mpq_cell: one storage slot of the queue row
// takes the right-hand neighbour's entry or a new entry; uses mpq_pkg
module mpq_cell (
    input  logic               clk,
    input  mpq_pkg::cell_ctrl_t ctrl,
    input  mpq_pkg::entry_t    next_entry,
    input  mpq_pkg::entry_t    new_entry,
    output mpq_pkg::entry_t    entry
);

    mpq_pkg::entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.take_new)
        begin
            entry_reg <= new_entry;
        end
        else if (ctrl.take_next)
        begin
            entry_reg <= next_entry;
        end
    end

    assign entry = entry_reg;

endmodule

>>> design/min_priority_queue.sv
// min_priority_queue: top level, a ring of mpq_cell slots with a minimum tracker at the head
// uses mpq_pkg and mpq_cell
//
// Holds up to DEPTH (value, priority) entries in arrival order. A transaction is taken when
// start is high and busy is low; its single result is registered and shown for exactly one
// cycle with done high, and the receiver cannot stall it. Insert, clear, an unused kind and a
// remove on an empty queue finish at once: the result follows in the next cycle and a new
// transaction may be taken in every cycle. A remove on a non-empty queue rotates the ring of
// slots once past the comparator at its head (S_SCAN), then closes the gap (S_COMPACT): busy
// is high through both states, and the registered done follows S_COMPACT.
module min_priority_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic signed [31:0] value,
    input  logic signed [15:0] priority_req,
    output logic        done,
    output logic [1:0]  status,
    output logic signed [31:0] out_value,
    output logic signed [15:0] out_priority,
    output logic [4:0]  occupancy
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_SCAN    = 2'd1;
    localparam logic [1:0] S_COMPACT = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [mpq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [mpq_pkg::IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [mpq_pkg::IDX_W-1:0]  best_idx_reg, best_idx_next;
    mpq_pkg::entry_t            best_reg, best_next;
    logic                       done_reg, done_next;
    logic [1:0]                 status_reg, status_next;
    logic [31:0]                out_value_reg, out_value_next;
    logic [15:0]                out_priority_reg, out_priority_next;

    logic                       accept;
    logic                       load;
    logic                       rotate;
    logic                       compact;
    mpq_pkg::entry_t            new_entry;
    mpq_pkg::entry_t            cell_entry [mpq_pkg::DEPTH];
    mpq_pkg::cell_ctrl_t        cell_ctrl  [mpq_pkg::DEPTH];

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    assign new_entry.value = value;
    assign new_entry.prio  = mpq_pkg::PRIO_WIDTH'(priority_req);

    assign load    = accept && (kind == mpq_pkg::KIND_INSERT)
                     && (count_reg != mpq_pkg::CNT_W'(mpq_pkg::DEPTH));
    assign rotate  = (state_reg == S_SCAN);
    assign compact = (state_reg == S_COMPACT);

    // ring of slots, each taking from its right-hand neighbour
    for (genvar i = 0; i < mpq_pkg::DEPTH; i++)
    begin : g_cell
        assign cell_ctrl[i].take_next = rotate
            || (compact && (mpq_pkg::IDX_W'(i) >= best_idx_reg));
        assign cell_ctrl[i].take_new  = load && (mpq_pkg::CNT_W'(i) == count_reg);

        mpq_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[i]),
            .next_entry (cell_entry[(i + 1) % mpq_pkg::DEPTH]),
            .new_entry  (new_entry),
            .entry      (cell_entry[i])
        );
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        scan_idx_next     = scan_idx_reg;
        best_idx_next     = best_idx_reg;
        best_next         = best_reg;
        done_next         = 1'b0;
        status_next       = status_reg;
        out_value_next    = out_value_reg;
        out_priority_next = out_priority_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next       = mpq_pkg::ST_DONE;
                    out_value_next    = '0;
                    out_priority_next = '0;
                    done_next         = 1'b1;
                    case (kind)
                        mpq_pkg::KIND_INSERT:
                        begin
                            if (load)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = mpq_pkg::ST_FULL;
                            end
                        end
                        mpq_pkg::KIND_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = mpq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                done_next     = 1'b0;
                                scan_idx_next = '0;
                                state_next    = S_SCAN;
                            end
                        end
                        mpq_pkg::KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // head slot holds entry scan_idx; strict less keeps the earliest on ties
                if (scan_idx_reg == '0)
                begin
                    best_next     = cell_entry[0];
                    best_idx_next = '0;
                end
                else if ((mpq_pkg::CNT_W'(scan_idx_reg) < count_reg)
                         && (cell_entry[0].prio < best_reg.prio))
                begin
                    best_next     = cell_entry[0];
                    best_idx_next = scan_idx_reg;
                end
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == mpq_pkg::IDX_W'(mpq_pkg::DEPTH - 1))
                begin
                    state_next = S_COMPACT;
                end
            end
            S_COMPACT:
            begin
                count_next        = count_reg - 1'b1;
                status_next       = mpq_pkg::ST_REMOVED;
                out_value_next    = best_reg.value;
                out_priority_next = 16'(best_reg.prio);
                done_next         = 1'b1;
                state_next        = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg     <= scan_idx_next;
        best_idx_reg     <= best_idx_next;
        best_reg         <= best_next;
        status_reg       <= status_next;
        out_value_reg    <= out_value_next;
        out_priority_reg <= out_priority_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_value    = out_value_reg;
    assign out_priority = out_priority_reg;
    assign occupancy    = 5'(count_reg);

    // checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a transaction is still in progress");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mpq_pkg::CNT_W'(mpq_pkg::DEPTH))
        else $error("entry count beyond depth");

    a_remove_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == mpq_pkg::KIND_REMOVE) && (count_reg != '0)) |=> busy)
        else $error("remove on a non-empty queue did not start a scan");

    a_quick_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind != mpq_pkg::KIND_REMOVE)) |=> (done && !busy))
        else $error("single-cycle transaction gave no result");

    a_removed_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == mpq_pkg::ST_REMOVED)) |-> (count_reg == $past(count_reg) - 1'b1))
        else $error("remove did not lower the count by one");

endmodule
